/* rtl/core/awnm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awnm_pkg
// Shared types and constants for the attitude window nearest-match core.
// ----------------------------------------------------------------------------
package awnm_pkg;

  // fixed field widths
  localparam int LEN_W      = 7;
  localparam int THR_W      = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_DIFF_W = 16;
  localparam int STATUS_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 1'd1;

  // reset values of the configuration registers
  localparam logic [THR_W-1:0] THR_RESET = 15'd2048;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd20;

  // op codes of an input transaction
  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_COMPARE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_MATCH    = 2'd0,
    STATUS_OUTLIER  = 2'd1,
    STATUS_NOT_FULL = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic push;         // append a command to the window
    logic capture;      // latch measured attitude
    logic check;        // outlier and fill check, start scan
    logic scan_step;    // issue one window read
    logic load_result;  // move result into output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_scan;      // check passed, scan needed
    logic last_issue;   // current read is the newest entry
    logic pipe_busy;    // compare pipeline still holds data
    logic out_busy;     // output register full and stalled
  } ctrl_sts_t;

endpackage

/* rtl/core/awnm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awnm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module awnm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/awnm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awnm_ctrl
// Sequencer for push, check, window scan and result hand-off.
// ----------------------------------------------------------------------------
module awnm_ctrl
  import awnm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      op_i,
  output logic      in_stall_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.push        = accept && (op_i == OP_PUSH);
    cmd_o.capture     = accept && (op_i == OP_COMPARE);
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.go_scan ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/awnm_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awnm_dpath
// Window pointers, configuration, outlier check, scan pipeline and output.
// ----------------------------------------------------------------------------
module awnm_dpath
  import awnm_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int ANGLE_WIDTH = 16,
  localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // input payload
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  // control
  input  ctrl_cmd_t                     cmd_i,
  output ctrl_sts_t                     sts_o,
  // window ram
  output logic                          ram_we_o,
  output logic [PTR_W-1:0]              ram_waddr_o,
  output logic [2*ANGLE_WIDTH-1:0]      ram_wdata_o,
  output logic                          ram_re_o,
  output logic [PTR_W-1:0]              ram_raddr_o,
  input  logic [2*ANGLE_WIDTH-1:0]      ram_rdata_i,
  // output
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic [OUT_DIFF_W-1:0]         min_roll_gap_o,
  output logic [OUT_DIFF_W-1:0]         min_pitch_gap_o,
  output logic [LEN_W-1:0]              roll_lag_o,
  output logic [LEN_W-1:0]              pitch_lag_o
);

  localparam int DIFF_W  = ANGLE_WIDTH + 1;
  localparam int CMP_W   = (DIFF_W > THR_W) ? DIFF_W : THR_W;
  localparam int LEN_CAP = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
  localparam int SUM_W   = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  function automatic logic [DIFF_W-1:0] abs_diff(
    input logic signed [ANGLE_WIDTH-1:0] a,
    input logic signed [ANGLE_WIDTH-1:0] b
  );
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(WINDOW_MAX - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [OUT_DIFF_W-1:0] sat_diff(input logic [DIFF_W-1:0] v);
    sat_diff = ((v >> OUT_DIFF_W) != '0) ? '1 : OUT_DIFF_W'(v);
  endfunction

  // configuration
  logic [THR_W-1:0] thr_q;
  logic [LEN_W-1:0] wlen_q;
  logic [LEN_W-1:0] len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      wlen_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_OUTLIER_THRESHOLD: thr_q  <= cfg_data_i;
        REG_WINDOW_LENGTH:     wlen_q <= LEN_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (wlen_q == '0) begin
      len = LEN_W'(1);
    end else if (wlen_q > LEN_W'(LEN_CAP)) begin
      len = LEN_W'(LEN_CAP);
    end else begin
      len = wlen_q;
    end
  end

  // window bookkeeping
  logic [PTR_W-1:0] wp_q;
  logic [LEN_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      count_q <= '0;
    end else if (cmd_i.push) begin
      wp_q    <= ptr_inc(wp_q);
      count_q <= (count_q >= len) ? len : count_q + LEN_W'(1);
    end
  end

  assign ram_we_o    = cmd_i.push;
  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = {roll_angle_i, pitch_angle_i};

  // measured and previous attitude
  logic signed [ANGLE_WIDTH-1:0] cur_roll_q, cur_pitch_q;
  logic signed [ANGLE_WIDTH-1:0] prev_roll_q, prev_pitch_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_roll_q  <= roll_angle_i;
      cur_pitch_q <= pitch_angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_roll_q  <= '0;
      prev_pitch_q <= '0;
    end else if (cmd_i.check) begin
      prev_roll_q  <= cur_roll_q;
      prev_pitch_q <= cur_pitch_q;
    end
  end

  logic    outlier, not_full;
  status_e chk_status;
  status_e res_status_q;

  assign outlier =
      (CMP_W'(abs_diff(prev_roll_q, cur_roll_q)) > CMP_W'(thr_q)) ||
      (CMP_W'(abs_diff(prev_pitch_q, cur_pitch_q)) > CMP_W'(thr_q));
  assign not_full   = (count_q < len);
  assign chk_status = outlier ? STATUS_OUTLIER : (not_full ? STATUS_NOT_FULL : STATUS_MATCH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) res_status_q <= chk_status;
  end

  // oldest entry of the scanned window
  logic [SUM_W-1:0] wp_ext, len_ext;
  logic [PTR_W-1:0] start;

  assign wp_ext  = SUM_W'(wp_q);
  assign len_ext = SUM_W'(len);
  assign start   = (wp_ext >= len_ext) ? PTR_W'(wp_ext - len_ext)
                                       : PTR_W'(wp_ext + SUM_W'(WINDOW_MAX) - len_ext);

  // read issue
  logic [PTR_W-1:0] rd_ptr_q;
  logic [LEN_W-1:0] issue_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      rd_ptr_q    <= start;
      issue_idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      rd_ptr_q    <= ptr_inc(rd_ptr_q);
      issue_idx_q <= issue_idx_q + LEN_W'(1);
    end
  end

  assign ram_re_o    = cmd_i.scan_step;
  assign ram_raddr_o = rd_ptr_q;

  // read data, difference and best-match stages
  logic              rd_valid_q, d_valid_q;
  logic [LEN_W-1:0]  rd_idx_q, d_idx_q;
  logic [DIFF_W-1:0] dr_q, dp_q;
  logic [DIFF_W-1:0] best_r_q, best_p_q;
  logic [LEN_W-1:0]  lag_r_q, lag_p_q;
  logic signed [ANGLE_WIDTH-1:0] rd_roll, rd_pitch;

  assign rd_roll  = ram_rdata_i[2*ANGLE_WIDTH-1:ANGLE_WIDTH];
  assign rd_pitch = ram_rdata_i[ANGLE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      d_valid_q  <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan_step;
      d_valid_q  <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) rd_idx_q <= issue_idx_q;
    if (rd_valid_q) begin
      dr_q    <= abs_diff(rd_roll, cur_roll_q);
      dp_q    <= abs_diff(rd_pitch, cur_pitch_q);
      d_idx_q <= rd_idx_q;
    end
    if (d_valid_q) begin
      // strict less: the oldest minimum wins
      if ((d_idx_q == '0) || (dr_q < best_r_q)) begin
        best_r_q <= dr_q;
        lag_r_q  <= len - d_idx_q;
      end
      if ((d_idx_q == '0) || (dp_q < best_p_q)) begin
        best_p_q <= dp_q;
        lag_p_q  <= len - d_idx_q;
      end
    end
  end

  // output register
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [OUT_DIFF_W-1:0] min_roll_q, min_pitch_q;
  logic [LEN_W-1:0]      roll_lag_q, pitch_lag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      status_q <= res_status_q;
      if (res_status_q == STATUS_MATCH) begin
        min_roll_q  <= sat_diff(best_r_q);
        min_pitch_q <= sat_diff(best_p_q);
        roll_lag_q  <= lag_r_q;
        pitch_lag_q <= lag_p_q;
      end else begin
        min_roll_q  <= '0;
        min_pitch_q <= '0;
        roll_lag_q  <= '0;
        pitch_lag_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign min_roll_gap_o  = min_roll_q;
  assign min_pitch_gap_o = min_pitch_q;
  assign roll_lag_o      = roll_lag_q;
  assign pitch_lag_o     = pitch_lag_q;

  assign sts_o.go_scan    = (chk_status == STATUS_MATCH);
  assign sts_o.last_issue = (issue_idx_q == len - LEN_W'(1));
  assign sts_o.pipe_busy  = rd_valid_q || d_valid_q;
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

endmodule

/* rtl/core/attitude_window_nearest_match_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attitude_window_nearest_match_core
// Sliding window of roll and pitch commands with nearest-match search.
// ----------------------------------------------------------------------------
// A push transaction (op 0) writes one roll/pitch command into the window ram
// in the cycle it is accepted and produces no result; pushes are taken back to
// back. A compare transaction (op 1) first checks the measured attitude for a
// jump larger than outlier_threshold against the previous compare, then that
// the window holds window_length commands, and if both pass scans the newest
// window_length entries from oldest to newest, one entry per cycle through the
// single read port of the window ram. Between its acceptance and the earliest
// next acceptance a compare that scans runs through check, one read per entry,
// the drain of the read and compare stages and the result load; one that does
// not scan goes from check to result load. The scan length sets the rate. The
// result sits in an output register, so the next transaction is taken while it
// waits; a compare that finds the register still full and stalled holds its
// result load until the register frees. Lags count samples back from the newest
// command; conversion to time is left to software. Angles are Q3.12.
module attitude_window_nearest_match_core
  import awnm_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // input transactions
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  // result transactions
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [STATUS_W-1:0]           status_o,
  output logic [OUT_DIFF_W-1:0]         min_roll_gap_o,
  output logic [OUT_DIFF_W-1:0]         min_pitch_gap_o,
  output logic [LEN_W-1:0]              roll_lag_o,
  output logic [LEN_W-1:0]              pitch_lag_o
);

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // window ram interface
  logic                     ram_we, ram_re;
  logic [PTR_W-1:0]         ram_waddr, ram_raddr;
  logic [2*ANGLE_WIDTH-1:0] ram_wdata, ram_rdata;

  // sequencer
  awnm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // pointers, checks, scan pipeline and output register
  awnm_dpath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .roll_angle_i    (roll_angle_i),
    .pitch_angle_i   (pitch_angle_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .min_roll_gap_o  (min_roll_gap_o),
    .min_pitch_gap_o (min_pitch_gap_o),
    .roll_lag_o      (roll_lag_o),
    .pitch_lag_o     (pitch_lag_o)
  );

  // command window, roll in the upper half, pitch in the lower half
  awnm_ram #(
    .WIDTH (2 * ANGLE_WIDTH),
    .DEPTH (WINDOW_MAX)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  // window is only written while no compare is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !in_stall_o && !ram_re)
    else $error("window written during a compare");

  // an accepted compare blocks further input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i == OP_COMPARE)) |=> in_stall_o)
    else $error("compare accepted without entering the check");

  // a match always reports a lag inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_MATCH)) |-> (roll_lag_o != '0) && (pitch_lag_o != '0))
    else $error("match reported with zero lag");

  // rejected compares carry zeroed result fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_MATCH)) |->
      (min_roll_gap_o == '0) && (min_pitch_gap_o == '0) &&
      (roll_lag_o == '0) && (pitch_lag_o == '0))
    else $error("rejected compare with non-zero result fields");
`endif

endmodule
